// ===== design/mbs_pkg.sv =====
// Package for the minimum bracket search core: word type, fixed-point constants,
// controller and phase encodings, and the command/status structs between the modules.
// No dependencies.
`default_nettype none

package mbs_pkg;

   localparam int unsigned FIELD_W       = 32;
   localparam int unsigned WORD_BITS_DEF = 32;

   // Divider geometry: |num| * 2^15 over |den|, both magnitudes.
   localparam int unsigned DVD_W = 47;
   localparam int unsigned DVS_W = 32;

   typedef logic signed [FIELD_W-1:0] word_type;

   // Golden ratio and the parabolic step limit, both Q16.16.
   localparam word_type GOLD_Q   = 32'sd106039;
   localparam word_type GLIMIT_Q = 32'sd6553600;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_WAIT_FA,
      PH_WAIT_FB,
      PH_WAIT_FC,
      PH_WAIT_INNER,
      PH_WAIT_OUTER,
      PH_WAIT_SHIFT,
      PH_DONE
   } phase_type;

   typedef enum logic [4:0] {
      CS_IDLE,
      CS_DISPATCH,
      CS_FA1,
      CS_FB1,
      CS_GB0,
      CS_GB1,
      CS_GB2,
      CS_GB3,
      CS_GC0,
      CS_GC1,
      CS_GC2,
      CS_L0,
      CS_L1,
      CS_L2,
      CS_L3,
      CS_L4,
      CS_L5,
      CS_L6,
      CS_L7,
      CS_L8,
      CS_L9,
      CS_L10,
      CS_DIVW,
      CS_L11,
      CS_L12,
      CS_L13,
      CS_L14,
      CS_L15,
      CS_EMIT
   } ctl_state_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_MOV,
      OP_ADD,
      OP_SUB,
      OP_MUL
   } alu_op_type;

   typedef enum logic [4:0] {
      RS_A,
      RS_B,
      RS_C,
      RS_FA,
      RS_FB,
      RS_FC,
      RS_U,
      RS_IN,
      RS_T1,
      RS_T2,
      RS_T3,
      RS_T4,
      RS_TR,
      RS_TQ,
      RS_TD,
      RS_TN,
      RS_TL,
      RS_QUO,
      RS_GOLD,
      RS_GLIM
   } reg_sel_type;

   typedef enum logic [2:0] {
      MV_NONE,
      MV_START,
      MV_SWAP,
      MV_SHIFT,
      MV_INNER_LO,
      MV_INNER_HI,
      MV_OUTER_LO
   } move_type;

   typedef struct packed {
      logic        capture;
      alu_op_type  alu_op;
      reg_sel_type src_x;
      reg_sel_type src_y;
      reg_sel_type dst;
      move_type    move;
      logic        div_start;
      logic        emit_req;
      logic        emit_bkt;
   } dp_cmd_type;

   typedef struct packed {
      logic action;
      logic fb_gt_fa;
      logic fb_gt_fc;
      logic in_lt_fc;
      logic in_gt_fb;
      logic u_inner;
      logic u_outer;
      logic u_lim;
      logic div_done;
   } dp_status_type;

   localparam dp_cmd_type DP_NOP = '{
      capture:   1'b0,
      alu_op:    OP_NONE,
      src_x:     RS_A,
      src_y:     RS_A,
      dst:       RS_A,
      move:      MV_NONE,
      div_start: 1'b0,
      emit_req:  1'b0,
      emit_bkt:  1'b0
   };

endpackage

`default_nettype wire

// ===== design/mbs_if.sv =====
// Valid/ready channel interfaces for the request and response sides of the core.
// Depends on mbs_pkg for the word type.
`default_nettype none

interface mbs_req_if import mbs_pkg::*; ();
   logic     valid;
   logic     ready;
   logic     action;
   word_type start_a;
   word_type start_b;
   word_type func_value;

   modport source (output valid, output action, output start_a, output start_b,
                   output func_value, input ready);
   modport sink   (input valid, input action, input start_a, input start_b,
                   input func_value, output ready);
endinterface

interface mbs_rsp_if import mbs_pkg::*; ();
   logic     valid;
   logic     ready;
   logic     kind;
   word_type eval_point;
   word_type bracket_a;
   word_type bracket_b;
   word_type bracket_c;
   word_type value_a;
   word_type value_b;
   word_type value_c;

   modport source (output valid, output kind, output eval_point, output bracket_a,
                   output bracket_b, output bracket_c, output value_a, output value_b,
                   output value_c, input ready);
   modport sink   (input valid, input kind, input eval_point, input bracket_a,
                   input bracket_b, input bracket_c, input value_a, input value_b,
                   input value_c, output ready);
endinterface

`default_nettype wire

// ===== design/mbs_div.sv =====
// Restoring radix-2 divider for unsigned magnitudes, one quotient bit per cycle.
// Depends on mbs_pkg for the dividend and divisor widths.
`default_nettype none

module mbs_div import mbs_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DVD_W-1:0] dividend,
   input  wire logic [DVS_W-1:0] divisor,
   output logic                  done,
   output logic [DVD_W-1:0]      quotient
);

   localparam int unsigned CNT_W = $clog2(DVD_W);

   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W:0]   rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DVS_W:0]   rem_sh;
   logic             ge;

   always_comb begin
      rem_sh  = {rem_ff[DVS_W-1:0], quo_ff[DVD_W-1]};
      ge      = (rem_sh >= {1'b0, dvs_ff});
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DVD_W-2:0], ge};
         rem_in = ge ? (rem_sh - {1'b0, dvs_ff}) : rem_sh;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ===== design/mbs_datapath.sv =====
// Datapath: search registers, saturating Q16.16 ALU, divider and response registers.
// Depends on mbs_pkg and mbs_div; driven by commands from mbs_ctrl.
`default_nettype none

module mbs_datapath import mbs_pkg::*; #(
   parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire dp_cmd_type    cmd,
   output dp_status_type      status,
   input  wire logic          req_action,
   input  wire word_type      req_start_a,
   input  wire word_type      req_start_b,
   input  wire word_type      req_func_value,
   output logic               rsp_kind,
   output word_type           rsp_eval_point,
   output word_type           rsp_bracket_a,
   output word_type           rsp_bracket_b,
   output word_type           rsp_bracket_c,
   output word_type           rsp_value_a,
   output word_type           rsp_value_b,
   output word_type           rsp_value_c
);

   localparam int unsigned EFF_BITS = (WORD_BITS > FIELD_W) ? FIELD_W : WORD_BITS;
   localparam logic signed [63:0] WMAX = (64'sd1 <<< (EFF_BITS - 1)) - 64'sd1;
   localparam logic signed [63:0] WMIN = -WMAX - 64'sd1;

   function automatic word_type sat64(input logic signed [63:0] v);
      logic signed [63:0] r;
      r = v;
      if (v > WMAX) r = WMAX;
      else if (v < WMIN) r = WMIN;
      return r[FIELD_W-1:0];
   endfunction

   function automatic logic signed [63:0] ext(input word_type v);
      return {{(64-FIELD_W){v[FIELD_W-1]}}, v};
   endfunction

   word_type a_ff, a_in, b_ff, b_in, c_ff, c_in;
   word_type fa_ff, fa_in, fb_ff, fb_in, fc_ff, fc_in;
   word_type u_ff, u_in;
   word_type t1_ff, t1_in, t2_ff, t2_in, t3_ff, t3_in, t4_ff, t4_in;
   word_type tr_ff, tr_in, tq_ff, tq_in, td_ff, td_in, tn_ff, tn_in, tl_ff, tl_in;
   logic     action_ff;
   word_type sa_ff, sb_ff, in_ff;
   logic     qneg_ff, qneg_in;

   logic               out_kind_ff;
   word_type           out_eval_ff, out_ba_ff, out_bb_ff, out_bc_ff;
   word_type           out_va_ff, out_vb_ff, out_vc_ff;

   logic [DVD_W-1:0]   div_q;
   logic               div_done;
   logic [DVD_W-1:0]   div_dvd;
   logic [DVS_W-1:0]   div_dvs;
   logic [FIELD_W:0]   num_abs, den_abs;
   logic signed [63:0] quo_ext;
   word_type           quo_sat;

   word_type           op_x, op_y, alu_res;
   logic signed [FIELD_W:0] add_w, sub_w;
   logic signed [63:0] prod_w;

   // Operand selection.
   function automatic word_type pick(input reg_sel_type s);
      word_type r;
      case (s)
         RS_A:    r = a_ff;
         RS_B:    r = b_ff;
         RS_C:    r = c_ff;
         RS_FA:   r = fa_ff;
         RS_FB:   r = fb_ff;
         RS_FC:   r = fc_ff;
         RS_U:    r = u_ff;
         RS_IN:   r = in_ff;
         RS_T1:   r = t1_ff;
         RS_T2:   r = t2_ff;
         RS_T3:   r = t3_ff;
         RS_T4:   r = t4_ff;
         RS_TR:   r = tr_ff;
         RS_TQ:   r = tq_ff;
         RS_TD:   r = td_ff;
         RS_TN:   r = tn_ff;
         RS_TL:   r = tl_ff;
         RS_QUO:  r = quo_sat;
         RS_GOLD: r = GOLD_Q;
         RS_GLIM: r = GLIMIT_Q;
         default: r = '0;
      endcase
      return r;
   endfunction

   // Divider operands: |num| * 2^16 / (2 * |den|) equals |num| * 2^15 / |den|.
   always_comb begin
      num_abs = tn_ff[FIELD_W-1] ? -{tn_ff[FIELD_W-1], tn_ff} : {tn_ff[FIELD_W-1], tn_ff};
      den_abs = td_ff[FIELD_W-1] ? -{td_ff[FIELD_W-1], td_ff} : {td_ff[FIELD_W-1], td_ff};
      div_dvd = {num_abs[FIELD_W-1:0], {(DVD_W-FIELD_W){1'b0}}};
      div_dvs = (den_abs[DVS_W-1:0] == '0) ? DVS_W'(1) : den_abs[DVS_W-1:0];
      qneg_in = cmd.div_start ? (tn_ff[FIELD_W-1] ^ td_ff[FIELD_W-1]) : qneg_ff;
      quo_ext = qneg_ff ? -$signed({{(64-DVD_W){1'b0}}, div_q})
                        :  $signed({{(64-DVD_W){1'b0}}, div_q});
      quo_sat = sat64(quo_ext);
   end

   mbs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .done     (div_done),
      .quotient (div_q)
   );

   // Saturating ALU; products round toward minus infinity.
   always_comb begin
      op_x   = pick(cmd.src_x);
      op_y   = pick(cmd.src_y);
      add_w  = {op_x[FIELD_W-1], op_x} + {op_y[FIELD_W-1], op_y};
      sub_w  = {op_x[FIELD_W-1], op_x} - {op_y[FIELD_W-1], op_y};
      prod_w = ext(op_x) * ext(op_y);
      case (cmd.alu_op)
         OP_MOV:  alu_res = sat64(ext(op_x));
         OP_ADD:  alu_res = sat64({{(63-FIELD_W){add_w[FIELD_W]}}, add_w});
         OP_SUB:  alu_res = sat64({{(63-FIELD_W){sub_w[FIELD_W]}}, sub_w});
         OP_MUL:  alu_res = sat64(prod_w >>> 16);
         default: alu_res = op_x;
      endcase
   end

   always_comb begin
      a_in = a_ff; b_in = b_ff; c_in = c_ff;
      fa_in = fa_ff; fb_in = fb_ff; fc_in = fc_ff;
      u_in = u_ff;
      t1_in = t1_ff; t2_in = t2_ff; t3_in = t3_ff; t4_in = t4_ff;
      tr_in = tr_ff; tq_in = tq_ff; td_in = td_ff; tn_in = tn_ff; tl_in = tl_ff;
      if (cmd.alu_op != OP_NONE) begin
         case (cmd.dst)
            RS_A:    a_in  = alu_res;
            RS_B:    b_in  = alu_res;
            RS_C:    c_in  = alu_res;
            RS_FA:   fa_in = alu_res;
            RS_FB:   fb_in = alu_res;
            RS_FC:   fc_in = alu_res;
            RS_U:    u_in  = alu_res;
            RS_T1:   t1_in = alu_res;
            RS_T2:   t2_in = alu_res;
            RS_T3:   t3_in = alu_res;
            RS_T4:   t4_in = alu_res;
            RS_TR:   tr_in = alu_res;
            RS_TQ:   tq_in = alu_res;
            RS_TD:   td_in = alu_res;
            RS_TN:   tn_in = alu_res;
            RS_TL:   tl_in = alu_res;
            default: ;
         endcase
      end
      case (cmd.move)
         MV_START: begin
            a_in = sat64(ext(sa_ff));
            b_in = sat64(ext(sb_ff));
            u_in = sat64(ext(sa_ff));
         end
         MV_SWAP: begin
            a_in  = b_ff;  b_in  = a_ff;
            fa_in = fb_ff; fb_in = fa_ff;
         end
         MV_SHIFT: begin
            a_in  = b_ff;  b_in  = c_ff;  c_in  = u_ff;
            fa_in = fb_ff; fb_in = fc_ff; fc_in = in_ff;
         end
         MV_INNER_LO: begin
            a_in  = b_ff;  b_in  = u_ff;
            fa_in = fb_ff; fb_in = in_ff;
         end
         MV_INNER_HI: begin
            c_in  = u_ff;  fc_in = in_ff;
         end
         MV_OUTER_LO: begin
            b_in  = c_ff;  c_in  = u_ff;
            fb_in = fc_ff; fc_in = in_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff  <= '0; b_ff  <= '0; c_ff  <= '0;
         fa_ff <= '0; fb_ff <= '0; fc_ff <= '0;
         u_ff  <= '0;
      end else begin
         a_ff  <= a_in;  b_ff  <= b_in;  c_ff  <= c_in;
         fa_ff <= fa_in; fb_ff <= fb_in; fc_ff <= fc_in;
         u_ff  <= u_in;
      end
      t1_ff <= t1_in; t2_ff <= t2_in; t3_ff <= t3_in; t4_ff <= t4_in;
      tr_ff <= tr_in; tq_ff <= tq_in; td_ff <= td_in; tn_ff <= tn_in; tl_ff <= tl_in;
      qneg_ff <= qneg_in;
      if (cmd.capture) begin
         action_ff <= req_action;
         sa_ff     <= req_start_a;
         sb_ff     <= req_start_b;
         in_ff     <= sat64(ext(req_func_value));
      end
      if (cmd.emit_req) begin
         out_kind_ff <= 1'b0;
         out_eval_ff <= u_ff;
         out_ba_ff <= '0; out_bb_ff <= '0; out_bc_ff <= '0;
         out_va_ff <= '0; out_vb_ff <= '0; out_vc_ff <= '0;
      end else if (cmd.emit_bkt) begin
         out_kind_ff <= 1'b1;
         out_eval_ff <= '0;
         out_ba_ff <= a_ff;  out_bb_ff <= b_ff;  out_bc_ff <= c_ff;
         out_va_ff <= fa_ff; out_vb_ff <= fb_ff; out_vc_ff <= fc_ff;
      end
   end

   // Position tests use exact comparisons of the stored words.
   always_comb begin
      status.action   = action_ff;
      status.fb_gt_fa = fb_ff > fa_ff;
      status.fb_gt_fc = fb_ff > fc_ff;
      status.in_lt_fc = in_ff < fc_ff;
      status.in_gt_fb = in_ff > fb_ff;
      status.u_inner  = ((b_ff > u_ff) && (u_ff > c_ff)) || ((b_ff < u_ff) && (u_ff < c_ff));
      status.u_outer  = ((c_ff > u_ff) && (u_ff > tl_ff)) || ((c_ff < u_ff) && (u_ff < tl_ff));
      status.u_lim    = ((u_ff >= tl_ff) && (tl_ff >= c_ff)) || ((u_ff <= tl_ff) && (tl_ff <= c_ff));
      status.div_done = div_done;
   end

   assign rsp_kind       = out_kind_ff;
   assign rsp_eval_point = out_eval_ff;
   assign rsp_bracket_a  = out_ba_ff;
   assign rsp_bracket_b  = out_bb_ff;
   assign rsp_bracket_c  = out_bc_ff;
   assign rsp_value_a    = out_va_ff;
   assign rsp_value_b    = out_vb_ff;
   assign rsp_value_c    = out_vc_ff;

endmodule

`default_nettype wire

// ===== design/mbs_ctrl.sv =====
// Controller: search phase register and the micro-step sequencer that drives the datapath.
// Depends on mbs_pkg for the state, phase and command types.
`default_nettype none

module mbs_ctrl import mbs_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   input  wire dp_status_type status,
   output dp_cmd_type         cmd
);

   ctl_state_type state_ff, state_in;
   phase_type     phase_ff, phase_in;
   logic          emit_bkt_ff, emit_bkt_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          slot_free;

   function automatic dp_cmd_type alu(input alu_op_type op, input reg_sel_type x,
                                      input reg_sel_type y, input reg_sel_type d);
      dp_cmd_type c;
      c        = DP_NOP;
      c.alu_op = op;
      c.src_x  = x;
      c.src_y  = y;
      c.dst    = d;
      return c;
   endfunction

   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      emit_bkt_in = emit_bkt_ff;
      cmd         = DP_NOP;
      slot_free   = !rsp_valid_ff || rsp_ready;
      case (state_ff)
         CS_IDLE: begin
            cmd.capture = req_valid;
            if (req_valid) state_in = CS_DISPATCH;
         end
         CS_DISPATCH: begin
            if (!status.action) begin
               cmd.move    = MV_START;
               phase_in    = PH_WAIT_FA;
               emit_bkt_in = 1'b0;
               state_in    = CS_EMIT;
            end else begin
               case (phase_ff)
                  PH_WAIT_FA: begin
                     cmd      = alu(OP_MOV, RS_IN, RS_IN, RS_FA);
                     state_in = CS_FA1;
                  end
                  PH_WAIT_FB: begin
                     cmd      = alu(OP_MOV, RS_IN, RS_IN, RS_FB);
                     state_in = CS_FB1;
                  end
                  PH_WAIT_FC: begin
                     cmd      = alu(OP_MOV, RS_IN, RS_IN, RS_FC);
                     state_in = CS_L0;
                  end
                  PH_WAIT_INNER: begin
                     if (status.in_lt_fc || status.in_gt_fb) begin
                        cmd.move    = status.in_lt_fc ? MV_INNER_LO : MV_INNER_HI;
                        phase_in    = PH_DONE;
                        emit_bkt_in = 1'b1;
                        state_in    = CS_EMIT;
                     end else begin
                        state_in = CS_GC0;
                     end
                  end
                  PH_WAIT_OUTER: begin
                     if (status.in_lt_fc) begin
                        cmd.move = MV_OUTER_LO;
                        state_in = CS_GC0;
                     end else begin
                        cmd.move = MV_SHIFT;
                        state_in = CS_L0;
                     end
                  end
                  PH_WAIT_SHIFT: begin
                     cmd.move = MV_SHIFT;
                     state_in = CS_L0;
                  end
                  default: begin
                     emit_bkt_in = 1'b1;
                     state_in    = CS_EMIT;
                  end
               endcase
            end
         end
         CS_FA1: begin
            cmd         = alu(OP_MOV, RS_B, RS_B, RS_U);
            phase_in    = PH_WAIT_FB;
            emit_bkt_in = 1'b0;
            state_in    = CS_EMIT;
         end
         CS_FB1: begin
            if (status.fb_gt_fa) cmd.move = MV_SWAP;
            state_in = CS_GB0;
         end
         CS_GB0: begin cmd = alu(OP_SUB, RS_B, RS_A, RS_T1);    state_in = CS_GB1; end
         CS_GB1: begin cmd = alu(OP_MUL, RS_GOLD, RS_T1, RS_T2); state_in = CS_GB2; end
         CS_GB2: begin cmd = alu(OP_ADD, RS_B, RS_T2, RS_C);    state_in = CS_GB3; end
         CS_GB3: begin
            cmd         = alu(OP_MOV, RS_C, RS_C, RS_U);
            phase_in    = PH_WAIT_FC;
            emit_bkt_in = 1'b0;
            state_in    = CS_EMIT;
         end
         CS_GC0: begin cmd = alu(OP_SUB, RS_C, RS_B, RS_T1);    state_in = CS_GC1; end
         CS_GC1: begin cmd = alu(OP_MUL, RS_GOLD, RS_T1, RS_T2); state_in = CS_GC2; end
         CS_GC2: begin
            cmd         = alu(OP_ADD, RS_C, RS_T2, RS_U);
            phase_in    = PH_WAIT_SHIFT;
            emit_bkt_in = 1'b0;
            state_in    = CS_EMIT;
         end
         CS_L0: begin
            if (!status.fb_gt_fc) begin
               phase_in    = PH_DONE;
               emit_bkt_in = 1'b1;
               state_in    = CS_EMIT;
            end else begin
               cmd      = alu(OP_SUB, RS_B, RS_A, RS_T1);
               state_in = CS_L1;
            end
         end
         CS_L1:  begin cmd = alu(OP_SUB, RS_B, RS_C, RS_T3);   state_in = CS_L2; end
         CS_L2:  begin cmd = alu(OP_SUB, RS_FB, RS_FC, RS_T2); state_in = CS_L3; end
         CS_L3:  begin cmd = alu(OP_MUL, RS_T1, RS_T2, RS_TR); state_in = CS_L4; end
         CS_L4:  begin cmd = alu(OP_SUB, RS_FB, RS_FA, RS_T2); state_in = CS_L5; end
         CS_L5:  begin cmd = alu(OP_MUL, RS_T3, RS_T2, RS_TQ); state_in = CS_L6; end
         CS_L6:  begin cmd = alu(OP_SUB, RS_TQ, RS_TR, RS_TD); state_in = CS_L7; end
         CS_L7:  begin cmd = alu(OP_MUL, RS_T3, RS_TQ, RS_T2); state_in = CS_L8; end
         CS_L8:  begin cmd = alu(OP_MUL, RS_T1, RS_TR, RS_T4); state_in = CS_L9; end
         CS_L9:  begin cmd = alu(OP_SUB, RS_T2, RS_T4, RS_TN); state_in = CS_L10; end
         CS_L10: begin cmd.div_start = 1'b1;                   state_in = CS_DIVW; end
         CS_DIVW: begin
            if (status.div_done) state_in = CS_L11;
         end
         CS_L11: begin cmd = alu(OP_SUB, RS_B, RS_QUO, RS_U);    state_in = CS_L12; end
         CS_L12: begin cmd = alu(OP_SUB, RS_C, RS_B, RS_T4);     state_in = CS_L13; end
         CS_L13: begin cmd = alu(OP_MUL, RS_GLIM, RS_T4, RS_T4); state_in = CS_L14; end
         CS_L14: begin cmd = alu(OP_ADD, RS_B, RS_T4, RS_TL);    state_in = CS_L15; end
         CS_L15: begin
            emit_bkt_in = 1'b0;
            if (status.u_inner) begin
               phase_in = PH_WAIT_INNER;
               state_in = CS_EMIT;
            end else if (status.u_outer) begin
               phase_in = PH_WAIT_OUTER;
               state_in = CS_EMIT;
            end else if (status.u_lim) begin
               cmd      = alu(OP_MOV, RS_TL, RS_TL, RS_U);
               phase_in = PH_WAIT_SHIFT;
               state_in = CS_EMIT;
            end else begin
               state_in = CS_GC0;
            end
         end
         CS_EMIT: begin
            if (slot_free) begin
               cmd.emit_req = !emit_bkt_ff;
               cmd.emit_bkt = emit_bkt_ff;
               state_in     = CS_IDLE;
            end
         end
         default: state_in = CS_IDLE;
      endcase

      if (cmd.emit_req || cmd.emit_bkt) rsp_valid_in = 1'b1;
      else if (rsp_ready)               rsp_valid_in = 1'b0;
      else                              rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CS_IDLE;
         phase_ff     <= PH_IDLE;
         emit_bkt_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         emit_bkt_ff  <= emit_bkt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == CS_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== design/minimum_bracket_search_core.sv =====
// Top level of the minimum bracket search core.
// Depends on mbs_pkg, mbs_if, mbs_div, mbs_datapath and mbs_ctrl.
//
// This core steers the search for a bracket around a minimum of a one-dimensional
// function whose values are computed outside. A start transfer (action 0) gives two
// abscissas and aborts any search in progress; every later transfer (action 1) returns
// the function value at the point last asked for. Each request transfer yields exactly
// one response transfer: either the next abscissa to evaluate (kind 0), or the finished
// bracket a, b, c with its three values (kind 1), where f(b) <= f(a) and f(b) <= f(c).
// The search runs downhill, extends by the golden ratio and tries parabolic steps
// limited to 100 times the current interval. All numbers are signed Q16.16 and every
// sum, difference, product and quotient saturates to the word set by WORD_BITS (capped
// at 32 bits); products round toward minus infinity, the parabolic quotient truncates
// toward zero. Unused response fields read as zero. The core handles one request at a
// time. The second value brings the swap and the first golden extension. A parabolic
// step waits on the bit-serial divider for its quotient, and may fall back to a golden
// extension. A response that is not taken holds back the loading of the next one. A
// response waits in an output register, so the next request is taken while the
// previous response still waits.
`default_nettype none

module minimum_bracket_search_core import mbs_pkg::*; #(
   parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   mbs_req_if.sink   req,
   mbs_rsp_if.source rsp
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // The sequencer decides which micro-step the datapath performs each cycle.
   mbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the bracket, the scratch terms, the divider and the response.
   mbs_datapath #(
      .WORD_BITS (WORD_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_action     (req.action),
      .req_start_a    (req.start_a),
      .req_start_b    (req.start_b),
      .req_func_value (req.func_value),
      .rsp_kind       (rsp.kind),
      .rsp_eval_point (rsp.eval_point),
      .rsp_bracket_a  (rsp.bracket_a),
      .rsp_bracket_b  (rsp.bracket_b),
      .rsp_bracket_c  (rsp.bracket_c),
      .rsp_value_a    (rsp.value_a),
      .rsp_value_b    (rsp.value_b),
      .rsp_value_c    (rsp.value_c)
   );

endmodule

`default_nettype wire
